/* src/arct_pkg.sv */
// arct_pkg: command and status codes, token and write-bus types for the
// address region table. No dependencies.
`timescale 1ns / 1ps

package arct_pkg;

  localparam int ADDR_W = 64;
  localparam int IDX_W  = 4;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // attribute bits of a region
  localparam int ATTR_R    = 0;
  localparam int ATTR_W    = 1;
  localparam int ATTR_X    = 2;
  localparam int ATTR_ANON = 3;

  // lookup token walking the cell chain
  typedef struct packed {
    logic              active;
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [3:0]        attr;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] delta;
  } token_t;

  // region write bus shared by all cells
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    logic [3:0]        attr;
    logic [ADDR_W-1:0] delta;
  } wr_t;

endpackage

/* src/arct_cell.sv */
// arct_cell: one region slot of the table and one stage of the lookup walk.
// Depends on arct_pkg.
`timescale 1ns / 1ps

module arct_cell #(
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            live,
  input  logic            wr_sel,
  input  arct_pkg::wr_t   wr,
  input  arct_pkg::token_t tok_in,
  output arct_pkg::token_t tok_out
);

  logic [arct_pkg::ADDR_W-1:0] start;
  logic [arct_pkg::ADDR_W-1:0] stop;
  logic [3:0]                  attr;
  logic [arct_pkg::ADDR_W-1:0] delta;
  arct_pkg::token_t            tok_next;

  always_comb begin
    tok_next = tok_in;
    // first live region holding the address claims the token
    if (tok_in.active && live && !tok_in.hit &&
        start <= tok_in.addr && stop > tok_in.addr) begin
      tok_next.hit   = 1'b1;
      tok_next.idx   = arct_pkg::IDX_W'(INDEX);
      tok_next.attr  = attr;
      tok_next.delta = delta;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_sel) begin
      start <= wr.start;
      stop  <= wr.stop;
      attr  <= wr.attr;
      delta <= wr.delta;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
    if (rst) begin
      tok_out.active <= 1'b0;
    end
  end

endmodule

/* src/address_region_table_fault_lookup.sv */
// address_region_table_fault_lookup: top level, command sequencer and chain of
// region cells. Depends on arct_pkg and arct_cell.
`timescale 1ns / 1ps

// Usage
// A command beat is taken on a rising edge where start is high and busy is
// low: cmd, address, region_length, region_flags and file_offset are sampled
// there. Every command gives exactly one result beat, shown for one cycle
// with done high; the receiver cannot stall it.
// Insert: busy while the region end and image delta are formed and the
// region is written in S_INS; the result is given from S_INS. A full table
// answers in the cycle after the command, without entering S_INS.
// Lookup: the fault address walks the chain of ENTRIES cells one cell per
// clock, and busy is high until the token leaves the last cell; the result
// is registered from the token at the end of the chain.
// Clear and the unused code: result in the cycle after the command.
// A new lookup is therefore not taken before the previous one has answered.
// Reset (rst, synchronous) empties the table and drops any walk in flight;
// region contents are not cleared, only the region count.

module address_region_table_fault_lookup #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [63:0] address,
  input  logic [63:0] region_length,
  input  logic [3:0]  region_flags,
  input  logic [63:0] file_offset,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  entry_index,
  output logic [4:0]  pte_flags,
  output logic [63:0] page_address,
  output logic        zero_fill,
  output logic [63:0] source_offset
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [63:0] PAGE_LOW  = (64'd1 << PAGE_SHIFT) - 64'd1;
  localparam logic [63:0] PAGE_MASK = ~PAGE_LOW;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_WALK} state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [63:0]        ins_start;
  logic [63:0]        ins_len;
  logic [63:0]        ins_foff;
  logic [3:0]         ins_attr;

  logic               accept;
  logic               table_full;
  arct_pkg::wr_t      wr;
  arct_pkg::token_t   tok [ENTRIES+1];
  logic [ENTRIES-1:0] live;
  logic [ENTRIES-1:0] wr_sel;
  arct_pkg::token_t   tail;
  logic [63:0]        tail_page;
  logic [63:0]        src_sum;

  assign accept     = start && !busy;
  assign table_full = (count == FULL_COUNT);
  assign busy       = (state != S_IDLE);

  // region write happens in the cycle after an insert beat
  always_comb begin
    wr.en    = (state == S_INS);
    wr.start = ins_start;
    wr.stop  = ins_start + ins_len;
    wr.attr  = ins_attr;
    wr.delta = ins_foff - ins_start;
  end

  always_comb begin
    tok[0].active = accept && (cmd == arct_pkg::CMD_LOOKUP);
    tok[0].hit    = 1'b0;
    tok[0].idx    = '0;
    tok[0].attr   = '0;
    tok[0].addr   = address;
    tok[0].delta  = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign live[i]   = (CNT_W'(i) < count);
    assign wr_sel[i] = (CNT_W'(i) == count);

    arct_cell #(
      .INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .live    (live[i]),
      .wr_sel  (wr_sel[i]),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign tail      = tok[ENTRIES];
  assign tail_page = tail.addr & PAGE_MASK;
  // image offset minus region start was stored at insert
  assign src_sum   = (tail.delta + tail_page) & PAGE_MASK;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            status        <= arct_pkg::ST_OK;
            entry_index   <= '0;
            pte_flags     <= '0;
            page_address  <= '0;
            zero_fill     <= 1'b0;
            source_offset <= '0;
            ins_start     <= address & PAGE_MASK;
            ins_len       <= (region_length + PAGE_LOW) & PAGE_MASK;
            ins_foff      <= file_offset;
            ins_attr      <= region_flags;
            case (cmd)
              arct_pkg::CMD_INSERT: begin
                if (table_full) begin
                  status <= arct_pkg::ST_FULL;
                  done   <= 1'b1;
                end else begin
                  state <= S_INS;
                end
              end
              arct_pkg::CMD_LOOKUP: begin
                state <= S_WALK;
              end
              arct_pkg::CMD_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_INS: begin
          entry_index  <= 4'(count);
          page_address <= ins_start;
          count        <= count + CNT_W'(1);
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        S_WALK: begin
          if (tail.active) begin
            page_address <= tail_page;
            if (tail.hit) begin
              status        <= arct_pkg::ST_OK;
              entry_index   <= tail.idx;
              pte_flags     <= {1'b1, tail.attr[arct_pkg::ATTR_X],
                                tail.attr[arct_pkg::ATTR_W],
                                tail.attr[arct_pkg::ATTR_R], 1'b1};
              zero_fill     <= tail.attr[arct_pkg::ATTR_ANON];
              source_offset <= tail.attr[arct_pkg::ATTR_ANON] ? '0 : src_sum;
            end else begin
              status <= arct_pkg::ST_MISS;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // every accepted beat either keeps the block busy or answers next cycle
  a_beat_answered: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted beat neither in progress nor answered");

  // a refused insert only happens on a full table
  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    (done && status == arct_pkg::ST_FULL) |-> table_full)
    else $error("insert refused while table not full");

  // the walk token only leaves the chain during a lookup
  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> (state == S_WALK))
    else $error("lookup token arrived outside a walk");

  // a zero-fill page never carries a source offset
  a_anon_no_src: assert property (@(posedge clk) disable iff (rst)
    (done && zero_fill) |-> (source_offset == '0 && status == arct_pkg::ST_OK))
    else $error("zero-fill result with source offset or bad status");

endmodule
